/* rtl/arr_pkg.sv */
// ----------------------------------------------------------------------------
// arr_pkg: shared types and constants
// Request and result records, angle reduction constants and the CORDIC
// arctangent table for the axis-angle rotation matrix block.
// ----------------------------------------------------------------------------
package arr_pkg;

   localparam int AXIS_W  = 16;
   localparam int ANGLE_W = 17;
   localparam int ENTRY_W = 16;
   localparam int SQ_W    = 32;
   localparam int ANG_W   = 19;
   localparam int CW      = 32;
   localparam int ENTRIES = 9;

   localparam logic signed [ANG_W-1:0] ANG_FULL    = 19'sd46080;
   localparam logic signed [ANG_W-1:0] ANG_HALF    = 19'sd23040;
   localparam logic signed [ANG_W-1:0] ANG_QUARTER = 19'sd11520;
   localparam logic signed [ANG_W-1:0] ANG_BIAS    = 19'sd92160;

   localparam logic signed [CW-1:0] CORDIC_X0 = 32'sd652032874;

   localparam int ATAN_LEN = 24;
   // atan(2^-i) in units of 2^-23 degree
   localparam logic signed [CW-1:0] ATAN_DEG [ATAN_LEN] = '{
      32'sd377487360, 32'sd222843801, 32'sd117744544, 32'sd59768969,
      32'sd30000467,  32'sd15014858,  32'sd7509261,   32'sd3754860,
      32'sd1877459,   32'sd938733,    32'sd469367,    32'sd234683,
      32'sd117342,    32'sd58671,     32'sd29335,     32'sd14668,
      32'sd7334,      32'sd3667,      32'sd1833,      32'sd917,
      32'sd458,       32'sd229,       32'sd115,       32'sd57
   };

   typedef struct packed {
      logic signed [AXIS_W-1:0] axis_x;
      logic signed [AXIS_W-1:0] axis_y;
      logic signed [AXIS_W-1:0] axis_z;
      logic [SQ_W-1:0]          sq;
      logic signed [CW-1:0]     z0;
      logic                     neg;
      logic                     zero;
   } arr_item_type;

   typedef struct packed {
      logic [ENTRIES-1:0][ENTRY_W-1:0] m;
      logic                            zero_axis;
   } arr_result_type;

endpackage

/* rtl/axis_angle_rotation_matrix.sv */
// Throughput: one request per cycle while the result queue is not full; the
// 32-stage square root and 31-stage divider pipelines set the depth, and each
// stage takes a new request a cycle unless the back pipeline is stalled.
// Reset: synchronous, clears all valid bits and queue pointers; no sweep needed.
// ----------------------------------------------------------------------------
// axis_angle_rotation_matrix: axis-angle to 3x3 rotation matrix
// Intake stage feeds a short queue; the back pipeline builds
// R = cos*I + (1-cos)*n*n^T + sin*[n]x into a two-entry result queue.
// ----------------------------------------------------------------------------
module axis_angle_rotation_matrix #(
   parameter int CORDIC_STEPS  = 16,
   parameter int OUT_FRAC_BITS = 14
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               push,
   output logic                               full,
   input  logic signed [arr_pkg::AXIS_W-1:0]  req_axis_x,
   input  logic signed [arr_pkg::AXIS_W-1:0]  req_axis_y,
   input  logic signed [arr_pkg::AXIS_W-1:0]  req_axis_z,
   input  logic signed [arr_pkg::ANGLE_W-1:0] req_angle_deg,
   input  logic                               pop,
   output logic                               empty,
   output logic signed [arr_pkg::ENTRY_W-1:0] rsp_m00,
   output logic signed [arr_pkg::ENTRY_W-1:0] rsp_m01,
   output logic signed [arr_pkg::ENTRY_W-1:0] rsp_m02,
   output logic signed [arr_pkg::ENTRY_W-1:0] rsp_m10,
   output logic signed [arr_pkg::ENTRY_W-1:0] rsp_m11,
   output logic signed [arr_pkg::ENTRY_W-1:0] rsp_m12,
   output logic signed [arr_pkg::ENTRY_W-1:0] rsp_m20,
   output logic signed [arr_pkg::ENTRY_W-1:0] rsp_m21,
   output logic signed [arr_pkg::ENTRY_W-1:0] rsp_m22,
   output logic                               rsp_zero_axis
);

   localparam int ITEM_W = $bits(arr_pkg::arr_item_type);
   localparam int RES_W  = $bits(arr_pkg::arr_result_type);

   logic                    fq_push, fq_full, fq_pop, fq_empty;
   arr_pkg::arr_item_type   fq_in, fq_out;
   logic                    rq_push, rq_full;
   arr_pkg::arr_result_type rq_in, rq_out;

   arr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .axis_x    (req_axis_x),
      .axis_y    (req_axis_y),
      .axis_z    (req_axis_z),
      .angle_deg (req_angle_deg),
      .q_push    (fq_push),
      .q_item    (fq_in),
      .q_full    (fq_full)
   );

   arr_fifo #(
      .WIDTH (ITEM_W),
      .DEPTH (4)
   ) u_work_q (
      .clock    (clock),
      .reset    (reset),
      .push     (fq_push),
      .data_in  (fq_in),
      .full     (fq_full),
      .pop      (fq_pop),
      .data_out (fq_out),
      .empty    (fq_empty)
   );

   arr_back #(
      .CORDIC_STEPS  (CORDIC_STEPS),
      .OUT_FRAC_BITS (OUT_FRAC_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (fq_empty),
      .q_item   (fq_out),
      .q_pop    (fq_pop),
      .o_full   (rq_full),
      .o_push   (rq_push),
      .o_result (rq_in)
   );

   arr_fifo #(
      .WIDTH (RES_W),
      .DEPTH (2)
   ) u_rsp_q (
      .clock    (clock),
      .reset    (reset),
      .push     (rq_push),
      .data_in  (rq_in),
      .full     (rq_full),
      .pop      (pop),
      .data_out (rq_out),
      .empty    (empty)
   );

   assign rsp_m00       = rq_out.m[0];
   assign rsp_m01       = rq_out.m[1];
   assign rsp_m02       = rq_out.m[2];
   assign rsp_m10       = rq_out.m[3];
   assign rsp_m11       = rq_out.m[4];
   assign rsp_m12       = rq_out.m[5];
   assign rsp_m20       = rq_out.m[6];
   assign rsp_m21       = rq_out.m[7];
   assign rsp_m22       = rq_out.m[8];
   assign rsp_zero_axis = rq_out.zero_axis;

endmodule

/* rtl/arr_fifo.sv */
// ----------------------------------------------------------------------------
// arr_fifo: small register queue
// Push/full on the write side, pop/empty on the read side, head shown directly.
// ----------------------------------------------------------------------------
module arr_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] data_in,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] data_out,
   output logic             empty
);

   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNTW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [CNTW-1:0]  cnt_ff, cnt_in;
   logic             do_wr, do_rd;

   assign full     = (cnt_ff == CNTW'(DEPTH));
   assign empty    = (cnt_ff == '0);
   assign do_wr    = push && !full;
   assign do_rd    = pop && !empty;
   assign data_out = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_wr) begin
         wr_in = (wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_in = (rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ff] <= data_in;
      end
   end

endmodule

/* rtl/arr_front.sv */
// ----------------------------------------------------------------------------
// arr_front: request intake
// Squares the axis, reduces and folds the angle, flags a zero axis.
// ----------------------------------------------------------------------------
module arr_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  push,
   output logic                                  full,
   input  logic signed [arr_pkg::AXIS_W-1:0]     axis_x,
   input  logic signed [arr_pkg::AXIS_W-1:0]     axis_y,
   input  logic signed [arr_pkg::AXIS_W-1:0]     axis_z,
   input  logic signed [arr_pkg::ANGLE_W-1:0]    angle_deg,
   output logic                                  q_push,
   output arr_pkg::arr_item_type                 q_item,
   input  logic                                  q_full
);

   logic                                 fen;
   logic                                 a_valid_ff, b_valid_ff;
   logic signed [arr_pkg::AXIS_W-1:0]    a_x_ff, a_y_ff, a_z_ff;
   logic signed [arr_pkg::ANGLE_W-1:0]   a_ang_ff;
   logic signed [arr_pkg::AXIS_W-1:0]    b_x_ff, b_y_ff, b_z_ff;
   logic [arr_pkg::SQ_W-1:0]             b_sqx_ff, b_sqy_ff, b_sqz_ff;
   logic [arr_pkg::SQ_W-1:0]             b_sqx_in, b_sqy_in, b_sqz_in;
   logic signed [arr_pkg::ANG_W-1:0]     b_ang_ff, b_ang_in;
   logic signed [2*arr_pkg::AXIS_W-1:0]  px, py, pz;
   logic signed [arr_pkg::ANG_W-1:0]     fold;
   logic                                 neg;

   assign fen    = !(b_valid_ff && q_full);
   assign full   = !fen;
   assign q_push = b_valid_ff && fen;

   always_comb begin
      px       = a_x_ff * a_x_ff;
      py       = a_y_ff * a_y_ff;
      pz       = a_z_ff * a_z_ff;
      b_sqx_in = arr_pkg::SQ_W'(px);
      b_sqy_in = arr_pkg::SQ_W'(py);
      b_sqz_in = arr_pkg::SQ_W'(pz);
      b_ang_in = arr_pkg::ANG_W'(a_ang_ff) + arr_pkg::ANG_BIAS;
      if (b_ang_in >= arr_pkg::ANG_BIAS) begin
         b_ang_in = b_ang_in - arr_pkg::ANG_BIAS;
      end
      if (b_ang_in >= arr_pkg::ANG_FULL) begin
         b_ang_in = b_ang_in - arr_pkg::ANG_FULL;
      end
   end

   always_comb begin
      fold = b_ang_ff;
      neg  = 1'b0;
      if (fold >= arr_pkg::ANG_HALF) begin
         fold = fold - arr_pkg::ANG_FULL;
      end
      if (fold > arr_pkg::ANG_QUARTER) begin
         fold = fold - arr_pkg::ANG_HALF;
         neg  = 1'b1;
      end else if (fold < -arr_pkg::ANG_QUARTER) begin
         fold = fold + arr_pkg::ANG_HALF;
         neg  = 1'b1;
      end
      q_item.axis_x = b_x_ff;
      q_item.axis_y = b_y_ff;
      q_item.axis_z = b_z_ff;
      q_item.sq     = b_sqx_ff + b_sqy_ff + b_sqz_ff;
      q_item.z0     = arr_pkg::CW'(fold) <<< 16;
      q_item.neg    = neg;
      q_item.zero   = (q_item.sq == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else if (fen) begin
         a_valid_ff <= push;
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fen) begin
         a_x_ff   <= axis_x;
         a_y_ff   <= axis_y;
         a_z_ff   <= axis_z;
         a_ang_ff <= angle_deg;
         b_x_ff   <= a_x_ff;
         b_y_ff   <= a_y_ff;
         b_z_ff   <= a_z_ff;
         b_sqx_ff <= b_sqx_in;
         b_sqy_ff <= b_sqy_in;
         b_sqz_ff <= b_sqz_in;
         b_ang_ff <= b_ang_in;
      end
   end

endmodule

/* rtl/arr_back.sv */
// ----------------------------------------------------------------------------
// arr_back: rotation matrix pipeline
// Square root with CORDIC alongside, three dividers, then matrix assembly,
// rounding and saturation. Stalls as a whole when its last stage holds a result and the result queue is full.
// ----------------------------------------------------------------------------
module arr_back #(
   parameter int CORDIC_STEPS  = 16,
   parameter int OUT_FRAC_BITS = 14
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_empty,
   input  arr_pkg::arr_item_type   q_item,
   output logic                    q_pop,
   input  logic                    o_full,
   output logic                    o_push,
   output arr_pkg::arr_result_type o_result
);

   localparam int CW      = arr_pkg::CW;
   localparam int ROOT_W  = 32;
   localparam int ROOT_ST = 32;
   localparam int REM_W   = 36;
   localparam int QUO_W   = 31;
   localparam int DREM_W  = 33;
   localparam int SUM_W   = 36;
   localparam int EW      = arr_pkg::ENTRY_W;
   localparam int NST     = (ROOT_ST + 1) + (QUO_W + 1) + 5;
   localparam int SH      = 30 - OUT_FRAC_BITS;
   localparam logic signed [SUM_W-1:0] RND = (36'sd1 <<< SH) >>> 1;
   localparam logic signed [SUM_W-1:0] LIM = 36'sd1 <<< OUT_FRAC_BITS;
   localparam logic signed [CW:0]      ONE = 33'sd1073741824;

   localparam int PI [6] = '{0, 0, 0, 1, 1, 2};
   localparam int PJ [6] = '{0, 1, 2, 1, 2, 2};
   localparam int PAIR_OF [9] = '{0, 1, 2, 1, 3, 4, 2, 4, 5};
   localparam int SKW [9] = '{0, -1, 1, 1, 0, -1, -1, 1, 0};
   localparam int SKI [9] = '{0, 2, 1, 2, 0, 0, 1, 0, 0};

   typedef struct packed {
      logic [2:0]                        sgn;
      logic [2:0][arr_pkg::AXIS_W-1:0]   mag;
      logic [arr_pkg::SQ_W-1:0]          sq;
      logic [REM_W-1:0]                  rem;
      logic [ROOT_W-1:0]                 root;
      logic [CW-1:0]                     cx;
      logic [CW-1:0]                     cy;
      logic [CW-1:0]                     cz;
      logic                              neg;
      logic                              zero;
   } root_stage_type;

   typedef struct packed {
      logic [2:0]              sgn;
      logic [2:0][DREM_W-1:0]  rem;
      logic [2:0][QUO_W-1:0]   quo;
      logic [ROOT_W-1:0]       root;
      logic [CW-1:0]           c;
      logic [CW-1:0]           s;
      logic                    zero;
   } div_stage_type;

   typedef struct packed {
      logic [2:0][CW-1:0] n;
      logic [CW-1:0]      c;
      logic [CW-1:0]      s;
      logic [CW:0]        omc;
      logic               zero;
   } norm_stage_type;

   typedef struct packed {
      logic [5:0][CW-1:0] nn;
      logic [2:0][CW-1:0] ts;
      logic [CW-1:0]      c;
      logic [CW:0]        omc;
      logic               zero;
   } prod_stage_type;

   typedef struct packed {
      logic [5:0][CW+1:0] t;
      logic [2:0][CW-1:0] ts;
      logic [CW-1:0]      c;
      logic               zero;
   } term_stage_type;

   typedef struct packed {
      logic [8:0][SUM_W-1:0] m;
      logic                  zero;
   } sum_stage_type;

   logic                    en;
   logic [NST-1:0]          vld_ff;
   root_stage_type          rt_ff [ROOT_ST+1];
   root_stage_type          rt0_in;
   div_stage_type           dv_ff [QUO_W+1];
   div_stage_type           dv0_in;
   norm_stage_type          nm_ff, nm_in;
   prod_stage_type          pr_ff, pr_in;
   term_stage_type          tm_ff, tm_in;
   sum_stage_type           sm_ff, sm_in;
   arr_pkg::arr_result_type rs_ff, rs_in;

   assign en       = !(vld_ff[NST-1] && o_full);
   assign q_pop    = en && !q_empty;
   assign o_push   = vld_ff[NST-1] && !o_full;
   assign o_result = rs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NST-2:0], q_pop};
      end
   end

   always_comb begin
      rt0_in.sgn  = {q_item.axis_z[arr_pkg::AXIS_W-1], q_item.axis_y[arr_pkg::AXIS_W-1],
                     q_item.axis_x[arr_pkg::AXIS_W-1]};
      rt0_in.mag[0] = q_item.axis_x[arr_pkg::AXIS_W-1] ? -q_item.axis_x : q_item.axis_x;
      rt0_in.mag[1] = q_item.axis_y[arr_pkg::AXIS_W-1] ? -q_item.axis_y : q_item.axis_y;
      rt0_in.mag[2] = q_item.axis_z[arr_pkg::AXIS_W-1] ? -q_item.axis_z : q_item.axis_z;
      rt0_in.sq   = q_item.sq;
      rt0_in.rem  = '0;
      rt0_in.root = '0;
      rt0_in.cx   = arr_pkg::CORDIC_X0;
      rt0_in.cy   = '0;
      rt0_in.cz   = q_item.z0;
      rt0_in.neg  = q_item.neg;
      rt0_in.zero = q_item.zero;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rt_ff[0] <= rt0_in;
      end
   end

   // square root of sq * 2^32, two radicand bits per stage; CORDIC rides along
   for (genvar k = 0; k < ROOT_ST; k++) begin : g_root
      localparam int AI = (k < arr_pkg::ATAN_LEN) ? k : 0;
      logic [63:0]          rad;
      logic [REM_W-1:0]     pre, trial;
      logic signed [CW-1:0] dx, dy;
      root_stage_type       step_in;

      always_comb begin
         rad     = {rt_ff[k].sq, 32'b0};
         pre     = {rt_ff[k].rem[REM_W-3:0], rad[63-2*k -: 2]};
         trial   = REM_W'({rt_ff[k].root, 2'b01});
         dx      = $signed(rt_ff[k].cy) >>> k;
         dy      = $signed(rt_ff[k].cx) >>> k;
         step_in = rt_ff[k];
         if (pre >= trial) begin
            step_in.rem  = pre - trial;
            step_in.root = {rt_ff[k].root[ROOT_W-2:0], 1'b1};
         end else begin
            step_in.rem  = pre;
            step_in.root = {rt_ff[k].root[ROOT_W-2:0], 1'b0};
         end
         if (k < CORDIC_STEPS && k < arr_pkg::ATAN_LEN) begin
            if (!rt_ff[k].cz[CW-1]) begin
               step_in.cx = $signed(rt_ff[k].cx) - dx;
               step_in.cy = $signed(rt_ff[k].cy) + dy;
               step_in.cz = $signed(rt_ff[k].cz) - arr_pkg::ATAN_DEG[AI];
            end else begin
               step_in.cx = $signed(rt_ff[k].cx) + dx;
               step_in.cy = $signed(rt_ff[k].cy) - dy;
               step_in.cz = $signed(rt_ff[k].cz) + arr_pkg::ATAN_DEG[AI];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rt_ff[k+1] <= step_in;
         end
      end
   end

   always_comb begin
      dv0_in.sgn  = rt_ff[ROOT_ST].sgn;
      for (int i = 0; i < 3; i++) begin
         dv0_in.rem[i] = DREM_W'({rt_ff[ROOT_ST].mag[i], 15'b0});
         dv0_in.quo[i] = '0;
      end
      dv0_in.root = rt_ff[ROOT_ST].root;
      dv0_in.c    = rt_ff[ROOT_ST].neg ? -rt_ff[ROOT_ST].cx : rt_ff[ROOT_ST].cx;
      dv0_in.s    = rt_ff[ROOT_ST].neg ? -rt_ff[ROOT_ST].cy : rt_ff[ROOT_ST].cy;
      dv0_in.zero = rt_ff[ROOT_ST].zero;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dv_ff[0] <= dv0_in;
      end
   end

   // |a| * 2^46 / root, one quotient bit per stage for each component
   for (genvar j = 0; j < QUO_W; j++) begin : g_div
      logic [2:0][DREM_W-1:0] pre;
      div_stage_type          step_in;

      always_comb begin
         step_in = dv_ff[j];
         for (int i = 0; i < 3; i++) begin
            pre[i] = {dv_ff[j].rem[i][DREM_W-2:0], 1'b0};
            if (pre[i] >= DREM_W'(dv_ff[j].root)) begin
               step_in.rem[i] = pre[i] - DREM_W'(dv_ff[j].root);
               step_in.quo[i] = {dv_ff[j].quo[i][QUO_W-2:0], 1'b1};
            end else begin
               step_in.rem[i] = pre[i];
               step_in.quo[i] = {dv_ff[j].quo[i][QUO_W-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            dv_ff[j+1] <= step_in;
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         nm_in.n[i] = dv_ff[QUO_W].sgn[i] ? -CW'(dv_ff[QUO_W].quo[i])
                                          : CW'(dv_ff[QUO_W].quo[i]);
      end
      nm_in.c    = dv_ff[QUO_W].c;
      nm_in.s    = dv_ff[QUO_W].s;
      nm_in.omc  = ONE - (CW+1)'($signed(dv_ff[QUO_W].c));
      nm_in.zero = dv_ff[QUO_W].zero;
   end

   always_comb begin
      logic signed [2*CW-1:0] pn;
      logic signed [2*CW-1:0] ps;
      pr_in.c    = nm_ff.c;
      pr_in.omc  = nm_ff.omc;
      pr_in.zero = nm_ff.zero;
      for (int p = 0; p < 6; p++) begin
         pn          = $signed(nm_ff.n[PI[p]]) * $signed(nm_ff.n[PJ[p]]);
         pr_in.nn[p] = pn[61:30];
      end
      for (int i = 0; i < 3; i++) begin
         ps          = $signed(nm_ff.s) * $signed(nm_ff.n[i]);
         pr_in.ts[i] = ps[61:30];
      end
   end

   always_comb begin
      logic signed [2*CW:0] pt;
      tm_in.ts   = pr_ff.ts;
      tm_in.c    = pr_ff.c;
      tm_in.zero = pr_ff.zero;
      for (int p = 0; p < 6; p++) begin
         pt         = $signed(pr_ff.nn[p]) * $signed(pr_ff.omc);
         tm_in.t[p] = pt[63:30];
      end
   end

   always_comb begin
      logic signed [SUM_W-1:0] acc;
      logic signed [SUM_W-1:0] skew;
      sm_in.zero = tm_ff.zero;
      for (int e = 0; e < 9; e++) begin
         acc  = SUM_W'($signed(tm_ff.t[PAIR_OF[e]]));
         skew = SUM_W'($signed(tm_ff.ts[SKI[e]]));
         if (e == 0 || e == 4 || e == 8) begin
            acc = acc + SUM_W'($signed(tm_ff.c));
         end
         if (SKW[e] > 0) begin
            acc = acc + skew;
         end else if (SKW[e] < 0) begin
            acc = acc - skew;
         end
         sm_in.m[e] = acc;
      end
   end

   always_comb begin
      logic signed [SUM_W-1:0] v;
      rs_in.zero_axis = sm_ff.zero;
      for (int e = 0; e < 9; e++) begin
         v = ($signed(sm_ff.m[e]) + RND) >>> SH;
         if (v > LIM) begin
            v = LIM;
         end else if (v < -LIM) begin
            v = -LIM;
         end
         if (sm_ff.zero) begin
            rs_in.m[e] = (e == 0 || e == 4 || e == 8) ? LIM[EW-1:0] : '0;
         end else begin
            rs_in.m[e] = v[EW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         nm_ff <= nm_in;
         pr_ff <= pr_in;
         tm_ff <= tm_in;
         sm_ff <= sm_in;
         rs_ff <= rs_in;
      end
   end

endmodule
